/* src/i2c_master_bit_sequencer_core_assert.svh */
// Assertion macros used by the I2C bit sequencer module i2cs_seq
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset
`define I2CS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset
`define I2CS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/i2cs_pkg.sv */
// Types and constants of the I2C master bit sequencer
`timescale 1ns / 1ps
`default_nettype none
package i2cs_pkg;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST1  = 5'd1,
        PH_ST2  = 5'd2,
        PH_ST3  = 5'd3,
        PH_ST4  = 5'd4,
        PH_SP1  = 5'd5,
        PH_SP2  = 5'd6,
        PH_SP3  = 5'd7,
        PH_WA1  = 5'd8,
        PH_WA2  = 5'd9,
        PH_WA3  = 5'd10,
        PH_AK1  = 5'd11,
        PH_AK2  = 5'd12,
        PH_TX1  = 5'd13,
        PH_TX2  = 5'd14,
        PH_TX3  = 5'd15,
        PH_RX1  = 5'd16,
        PH_RX2  = 5'd17,
        PH_STAT = 5'd18
    } phase_t;

    localparam logic [3:0] MODE_NONE   = 4'd0;
    localparam logic [3:0] MODE_START  = 4'd1;
    localparam logic [3:0] MODE_STOP   = 4'd2;
    localparam logic [3:0] MODE_SEND   = 4'd3;
    localparam logic [3:0] MODE_WAIT   = 4'd4;
    localparam logic [3:0] MODE_READ   = 4'd5;
    localparam logic [3:0] MODE_ACK    = 4'd6;
    localparam logic [3:0] MODE_NACK   = 4'd7;
    localparam logic [3:0] MODE_STATUS = 4'd8;

    localparam logic REG_TICKS_PER_US = 1'b0;
    localparam logic REG_ACK_TIMEOUT  = 1'b1;

    localparam logic [7:0] TICKS_PER_US_RST = 8'd8;
    localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

    localparam int BITS_PER_BYTE = 8;

    typedef struct packed {
        logic [7:0] ticks_per_us;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] tx_byte;
        logic       sda_in;
        logic       scl_in;
    } req_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       scl_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
        logic [1:0] bus_status;
    } res_t;

endpackage
`default_nettype wire

/* src/i2cs_cfg.sv */
// APB configuration registers of the I2C bit sequencer
`timescale 1ns / 1ps
`default_nettype none
module i2cs_cfg
    import i2cs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_us <= TICKS_PER_US_RST;
            cfg_reg.ack_timeout  <= ACK_TIMEOUT_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TICKS_PER_US: cfg_reg.ticks_per_us <= pwdata[7:0];
                REG_ACK_TIMEOUT:  cfg_reg.ack_timeout  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TICKS_PER_US: prdata = {24'd0, cfg_reg.ticks_per_us};
            REG_ACK_TIMEOUT:  prdata = {24'd0, cfg_reg.ack_timeout};
            default:          prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

/* src/i2cs_seq.sv */
// Bus phase sequencer: state registers and per-tick next-state logic
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_bit_sequencer_core_assert.svh"
module i2cs_seq
    import i2cs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic accept,
    input  wire cfg_t cfg,
    input  wire req_t req,
    output res_t      res
);

    phase_t      phase_reg, phase_next;
    logic [10:0] dly_reg, dly_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [8:0]  wait_reg, wait_next;
    logic [3:0]  cmd_reg, cmd_next;
    logic        scl_lv_reg, scl_lv_next;
    logic        sda_lv_reg, sda_lv_next;
    logic        scl_drv_reg, scl_drv_next;
    logic        sda_drv_reg, sda_drv_next;
    logic [7:0]  rd_reg, rd_next;
    logic        ackerr_reg, ackerr_next;
    logic [1:0]  stat_reg, stat_next;

    logic        done;
    logic        do_enter;
    phase_t      ent;
    logic        do_poll;
    logic        do_load;
    logic [2:0]  load_us;
    logic [7:0]  ticks_eff;

    assign ticks_eff = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;

    always_comb begin
        phase_next   = phase_reg;
        dly_next     = dly_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        wait_next    = wait_reg;
        cmd_next     = cmd_reg;
        scl_lv_next  = scl_lv_reg;
        sda_lv_next  = sda_lv_reg;
        scl_drv_next = scl_drv_reg;
        sda_drv_next = sda_drv_reg;
        rd_next      = rd_reg;
        ackerr_next  = ackerr_reg;
        stat_next    = stat_reg;
        done         = 1'b0;
        do_enter     = 1'b0;
        ent          = PH_IDLE;
        do_poll      = 1'b0;
        do_load      = 1'b0;
        load_us      = 3'd0;

        if (phase_reg == PH_IDLE) begin
            if (req.mode >= MODE_START && req.mode <= MODE_STATUS) begin
                cmd_next = req.mode;
                bit_next = 4'd0;
                do_enter = 1'b1;
                case (req.mode)
                    MODE_START: ent = PH_ST1;
                    MODE_STOP:  ent = PH_SP1;
                    MODE_SEND: begin
                        shift_next   = req.tx_byte;
                        sda_drv_next = 1'b1;
                        scl_drv_next = 1'b1;
                        scl_lv_next  = 1'b0;
                        ent          = PH_TX1;
                    end
                    MODE_WAIT:  ent = PH_WA1;
                    MODE_READ: begin
                        shift_next   = 8'd0;
                        sda_drv_next = 1'b0;
                        scl_drv_next = 1'b1;
                        ent          = PH_RX1;
                    end
                    MODE_ACK, MODE_NACK: ent = PH_AK1;
                    default: ent = PH_STAT;
                endcase
            end
        end else if (phase_reg == PH_WA3) begin
            do_poll = 1'b1;
        end else if (dly_reg > 11'd1) begin
            dly_next = dly_reg - 11'd1;
        end else begin
            unique case (phase_reg)
                PH_ST1: begin do_enter = 1'b1; ent = PH_ST2; end
                PH_ST2: begin do_enter = 1'b1; ent = PH_ST3; end
                PH_ST3: begin do_enter = 1'b1; ent = PH_ST4; end
                PH_SP1: begin do_enter = 1'b1; ent = PH_SP2; end
                PH_SP2: begin do_enter = 1'b1; ent = PH_SP3; end
                PH_WA1: begin do_enter = 1'b1; ent = PH_WA2; end
                PH_WA2: begin
                    phase_next = PH_WA3;
                    wait_next  = 9'd0;
                    do_poll    = 1'b1;
                end
                PH_AK1: begin do_enter = 1'b1; ent = PH_AK2; end
                PH_AK2: begin
                    scl_lv_next = 1'b0;
                    phase_next  = PH_IDLE;
                    done        = 1'b1;
                end
                PH_TX1: begin do_enter = 1'b1; ent = PH_TX2; end
                PH_TX2: begin do_enter = 1'b1; ent = PH_TX3; end
                PH_TX3: begin
                    bit_next = bit_reg + 4'd1;
                    if (bit_next >= 4'(BITS_PER_BYTE)) begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end else begin
                        do_enter = 1'b1;
                        ent      = PH_TX1;
                    end
                end
                PH_RX1: begin
                    phase_next  = PH_RX2;
                    scl_lv_next = 1'b1;
                    shift_next  = {shift_reg[6:0], req.sda_in};
                    do_load     = 1'b1;
                    load_us     = 3'd1;
                end
                PH_RX2: begin
                    bit_next = bit_reg + 4'd1;
                    if (bit_next >= 4'(BITS_PER_BYTE)) begin
                        rd_next    = shift_reg;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end else begin
                        do_enter = 1'b1;
                        ent      = PH_RX1;
                    end
                end
                PH_STAT: begin
                    stat_next  = {~req.sda_in, ~req.scl_in};
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                default: begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            endcase
        end

        if (do_poll) begin
            if (!req.sda_in) begin
                scl_lv_next = 1'b0;
                ackerr_next = 1'b0;
                phase_next  = PH_IDLE;
                done        = 1'b1;
            end else begin
                wait_next = wait_next + 9'd1;
                if (wait_next > {1'b0, cfg.ack_timeout}) begin
                    ackerr_next = 1'b1;
                    do_enter    = 1'b1;
                    ent         = PH_SP1;
                end
            end
        end

        if (do_enter) begin
            phase_next = ent;
            do_load    = 1'b1;
            unique case (ent)
                PH_ST1: begin
                    sda_lv_next = 1'b1; sda_drv_next = 1'b1; scl_drv_next = 1'b1;
                    load_us = 3'd1;
                end
                PH_ST2: begin scl_lv_next = 1'b1; load_us = 3'd5; end
                PH_ST3: begin sda_lv_next = 1'b0; load_us = 3'd6; end
                PH_ST4: begin scl_lv_next = 1'b0; load_us = 3'd2; end
                PH_SP1: begin
                    sda_drv_next = 1'b1; scl_drv_next = 1'b1;
                    scl_lv_next  = 1'b0; sda_lv_next  = 1'b0;
                    load_us = 3'd4;
                end
                PH_SP2: begin scl_lv_next = 1'b1; load_us = 3'd6; end
                PH_SP3: begin sda_lv_next = 1'b1; load_us = 3'd6; end
                PH_WA1: begin
                    sda_drv_next = 1'b0; sda_lv_next = 1'b1; scl_drv_next = 1'b1;
                    load_us = 3'd2;
                end
                PH_WA2: begin scl_lv_next = 1'b1; load_us = 3'd2; end
                PH_AK1: begin
                    scl_drv_next = 1'b1; scl_lv_next = 1'b0; sda_drv_next = 1'b1;
                    sda_lv_next  = (cmd_next == MODE_NACK);
                    load_us = 3'd2;
                end
                PH_AK2: begin scl_lv_next = 1'b1; load_us = 3'd5; end
                PH_TX1: begin
                    sda_lv_next = shift_next[7];
                    shift_next  = {shift_next[6:0], 1'b0};
                    load_us = 3'd2;
                end
                PH_TX2: begin scl_lv_next = 1'b1; load_us = 3'd2; end
                PH_TX3: begin scl_lv_next = 1'b0; load_us = 3'd2; end
                PH_RX1: begin scl_lv_next = 1'b0; load_us = 3'd2; end
                PH_STAT: begin
                    sda_drv_next = 1'b0; scl_drv_next = 1'b0;
                    load_us = 3'd1;
                end
                default: begin
                    phase_next = PH_IDLE;
                    do_load    = 1'b0;
                end
            endcase
        end

        if (do_load) begin
            dly_next = {8'd0, load_us} * {3'd0, ticks_eff};
        end
    end

    always_comb begin
        res.scl_level  = scl_lv_next;
        res.sda_level  = sda_lv_next;
        res.sda_drive  = sda_drv_next;
        res.scl_drive  = scl_drv_next;
        res.busy_res   = (phase_next != PH_IDLE);
        res.done_res   = done;
        res.read_data  = rd_next;
        res.ack_error  = ackerr_next;
        res.bus_status = stat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            dly_reg     <= 11'd0;
            bit_reg     <= 4'd0;
            shift_reg   <= 8'd0;
            wait_reg    <= 9'd0;
            cmd_reg     <= MODE_NONE;
            scl_lv_reg  <= 1'b1;
            sda_lv_reg  <= 1'b1;
            scl_drv_reg <= 1'b1;
            sda_drv_reg <= 1'b1;
            rd_reg      <= 8'd0;
            ackerr_reg  <= 1'b0;
            stat_reg    <= 2'd0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            dly_reg     <= dly_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            wait_reg    <= wait_next;
            cmd_reg     <= cmd_next;
            scl_lv_reg  <= scl_lv_next;
            sda_lv_reg  <= sda_lv_next;
            scl_drv_reg <= scl_drv_next;
            sda_drv_reg <= sda_drv_next;
            rd_reg      <= rd_next;
            ackerr_reg  <= ackerr_next;
            stat_reg    <= stat_next;
        end
    end

    `I2CS_ASSERT_NXT(a_done_idle, accept && done, phase_reg == PH_IDLE, "done without idle")
    `I2CS_ASSERT_IMP(a_bit_range,
        phase_reg == PH_TX1 || phase_reg == PH_TX2 || phase_reg == PH_TX3 ||
        phase_reg == PH_RX1 || phase_reg == PH_RX2,
        bit_reg < 4'(BITS_PER_BYTE), "bit count past byte")
    `I2CS_ASSERT_IMP(a_stat_release, phase_reg == PH_STAT,
        !scl_drv_reg && !sda_drv_reg, "lines driven during status")
    `I2CS_ASSERT_IMP(a_wait_bound, phase_reg == PH_WA3,
        !sda_drv_reg && wait_reg <= {1'b0, cfg.ack_timeout}, "ack wait past timeout")

endmodule
`default_nettype wire

/* src/i2c_master_bit_sequencer_core.sv */
// Top level of the I2C master bit sequencer
//
// One request on the s_ channel is one bus clock tick. s_tuser carries the
// command (0 none, 1 start, 2 stop, 3 send byte, 4 wait ack, 5 read byte,
// 6 ack, 7 nack, 8 status); s_tdata carries the byte to send and the sampled
// SDA and SCL levels. Each request yields exactly one result on the m_
// channel: the pin levels and directions to apply, busy and done flags and
// the last read byte, ack error and bus status. Commands are taken only
// while idle; others are ignored. Bus delays are microsecond counts times
// the ticks_per_us register, written over the APB port along with the ack
// timeout. Each result is registered as its request is taken; throughput
// is one request per cycle, limited only by the single result register,
// which keeps taking requests while the receiver takes its content. When m_tready
// is low with a result held, s_tready drops. Reset leaves the sequencer
// idle with both lines driven high and the result register empty.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_bit_sequencer_core
    import i2cs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // tx_byte[7:0], sda_in[8], scl_in[9], zero fill
    input  wire logic [3:0]  s_tuser,  // mode[3:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // scl_level, sda_level, sda_drive, scl_drive,
                                       // busy_res, done_res, read_data[13:6],
                                       // ack_error[14], bus_status[16:15], zero fill
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t        cfg;
    req_t        req;
    res_t        res;
    logic        accept;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic [23:0] m_tdata_next;

    i2cs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign req = {s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9]};

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    i2cs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .cfg     (cfg),
        .req     (req),
        .res     (res)
    );

    assign m_tdata_next = {7'd0, res.bus_status, res.ack_error, res.read_data,
                           res.done_res, res.busy_res, res.scl_drive, res.sda_drive,
                           res.sda_level, res.scl_level};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire
